FILE: hw/rtl/ihexd_pkg.sv
// Shared types, constants and character helpers for the hex record decoder.
package ihexd_pkg;

  // Queue between the character classifier and the record parser
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [15:0] REC_MAX   = 16'hFFFF;

  typedef enum logic [2:0] {
    PH_START = 3'd0,
    PH_COUNT = 3'd1,
    PH_ADDR  = 3'd2,
    PH_TYPE  = 3'd3,
    PH_DATA  = 3'd4,
    PH_CSUM  = 3'd5,
    PH_DONE  = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_WARN = 2'd1,
    KIND_OK   = 2'd2,
    KIND_FAIL = 2'd3
  } kind_t;

  // Classified character as it travels from front to back
  typedef struct packed {
    logic       colon;
    logic       space;
    logic       hex;
    logic [3:0] nib;
  } item_t;

  function automatic item_t classify(input logic [7:0] c);
    item_t it;
    it.colon = (c == CHAR_COLON);
    it.space = (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
    it.hex   = 1'b1;
    it.nib   = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      it.nib = c[3:0];
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      it.nib = 4'(c[2:0] + 3'd1) + 4'd8;
    end else begin
      it.hex = 1'b0;
    end
    return it;
  endfunction

endpackage

FILE: hw/rtl/ihexd_if.sv
// Valid/ready channel interfaces for characters in and decoded results out.
interface ihexd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;

  modport source (output valid, output char_in, input ready);
  modport sink   (input valid, input char_in, output ready);
endinterface

interface ihexd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  data_byte;
  logic [15:0] byte_address;
  logic [15:0] record_number;

  modport source (output valid, output kind, output data_byte, output byte_address,
                  output record_number, input ready);
  modport sink   (input valid, input kind, input data_byte, input byte_address,
                  input record_number, output ready);
endinterface

FILE: hw/rtl/ihexd_front.sv
// Front end: accept characters and classify them for the parser queue.
module ihexd_front (
  ihexd_in_if.sink         in_ch,
  input  logic             push_ready,
  output logic             push_valid,
  output ihexd_pkg::item_t push_item
);
  import ihexd_pkg::*;

  // Take a request whenever the queue has room
  assign in_ch.ready = push_ready;
  assign push_valid  = in_ch.valid;

  // Decode the character into colon, whitespace and hex digit flags
  assign push_item = classify(in_ch.char_in);

endmodule

FILE: hw/rtl/ihexd_queue.sv
// Short queue of classified characters between front end and parser.
module ihexd_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  ihexd_pkg::item_t push_item,
  output logic             pop_valid,
  input  logic             pop_ready,
  output ihexd_pkg::item_t pop_item
);
  import ihexd_pkg::*;

  item_t             mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              push, pop;

  assign push_ready = (cnt_r != QCNT_W'(QDEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_item   = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the pushed entry
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QDEPTH))
    else $error("queue count above depth");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    wr_ptr_r == QPTR_W'(rd_ptr_r + QPTR_W'(cnt_r)))
    else $error("queue pointers disagree with count");
`endif

endmodule

FILE: hw/rtl/ihexd_back.sv
// Back end: record parser state machine with a registered result stage.
module ihexd_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             pop_valid,
  output logic             pop_ready,
  input  ihexd_pkg::item_t pop_item,
  ihexd_out_if.source      out_ch
);
  import ihexd_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [1:0]  digit_r, digit_nxt;
  logic [3:0]  high_r, high_nxt;
  logic [7:0]  remain_r, remain_nxt;
  logic [15:0] addr_r, addr_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [15:0] rec_r, rec_nxt;

  logic        out_valid_r, out_valid_nxt;
  kind_t       kind_r;
  logic [7:0]  data_r;
  logic [15:0] baddr_r;
  logic [15:0] recno_r;

  logic        go;
  logic        emit;
  kind_t       res_kind;
  logic [7:0]  res_data;
  logic [15:0] res_addr;
  logic [7:0]  pair;
  logic [15:0] addr_shift;

  // Pull a request when the result stage is free or draining
  assign pop_ready  = !out_valid_r || out_ch.ready;
  assign go         = pop_valid && pop_ready;
  assign pair       = {high_r, pop_item.nib};
  assign addr_shift = {addr_r[11:0], pop_item.nib};

  // Next phase
  always_comb begin
    phase_nxt = phase_r;
    unique case (phase_r)
      PH_START: begin
        if (pop_item.colon) begin
          phase_nxt = PH_COUNT;
        end else if (!(rec_r > 16'd1 && pop_item.space)) begin
          phase_nxt = PH_DONE;
        end
      end
      PH_TYPE: begin
        if (digit_r != 2'd0) begin
          phase_nxt = (remain_r != 8'd0) ? PH_DATA : PH_CSUM;
        end
      end
      PH_COUNT, PH_ADDR, PH_DATA, PH_CSUM: begin
        if (!pop_item.hex) begin
          phase_nxt = PH_DONE;
        end else if (phase_r == PH_ADDR) begin
          if (digit_r == 2'd3) phase_nxt = PH_TYPE;
        end else if (digit_r != 2'd0) begin
          priority case (phase_r)
            PH_COUNT: phase_nxt = (pair == 8'd0) ? PH_DONE : PH_ADDR;
            PH_DATA:  phase_nxt = (remain_r == 8'd1) ? PH_CSUM : PH_DATA;
            default:  phase_nxt = PH_START;
          endcase
        end
      end
      default: phase_nxt = phase_r;
    endcase
  end

  // Field registers and result for the current character
  always_comb begin
    digit_nxt  = digit_r;
    high_nxt   = high_r;
    remain_nxt = remain_r;
    addr_nxt   = addr_r;
    sum_nxt    = sum_r;
    rec_nxt    = rec_r;
    emit       = 1'b0;
    res_kind   = KIND_DATA;
    res_data   = 8'd0;
    res_addr   = 16'd0;
    unique case (phase_r)
      PH_START: begin
        if (pop_item.colon) begin
          digit_nxt = 2'd0;
        end else if (!(rec_r > 16'd1 && pop_item.space)) begin
          emit     = 1'b1;
          res_kind = KIND_FAIL;
        end
      end
      PH_TYPE: begin
        digit_nxt = (digit_r == 2'd0) ? 2'd1 : 2'd0;
      end
      PH_COUNT, PH_ADDR, PH_DATA, PH_CSUM: begin
        if (!pop_item.hex) begin
          emit     = 1'b1;
          res_kind = KIND_FAIL;
        end else if (phase_r == PH_ADDR) begin
          addr_nxt = addr_shift;
          if (digit_r != 2'd3) begin
            digit_nxt = digit_r + 2'd1;
          end else begin
            digit_nxt = 2'd0;
            sum_nxt   = sum_r + addr_shift[15:8] + addr_shift[7:0];
          end
        end else if (digit_r == 2'd0) begin
          high_nxt  = pop_item.nib;
          digit_nxt = 2'd1;
        end else begin
          digit_nxt = 2'd0;
          priority case (phase_r)
            PH_COUNT: begin
              remain_nxt = pair;
              sum_nxt    = pair;
              addr_nxt   = 16'd0;
              if (pair == 8'd0) begin
                emit     = 1'b1;
                res_kind = KIND_OK;
              end
            end
            PH_DATA: begin
              emit       = 1'b1;
              res_kind   = KIND_DATA;
              res_data   = pair;
              res_addr   = addr_r;
              sum_nxt    = sum_r + pair;
              addr_nxt   = addr_r + 16'd1;
              remain_nxt = remain_r - 8'd1;
            end
            default: begin
              // Checksum field: warn on mismatch, then count the record
              if ((8'd0 - sum_r) != pair) begin
                emit     = 1'b1;
                res_kind = KIND_WARN;
              end
              if (rec_r != REC_MAX) rec_nxt = rec_r + 16'd1;
            end
          endcase
        end
      end
      default: begin
      end
    endcase
  end

  // Hold the result until the sink takes it
  always_comb begin
    if (go) begin
      out_valid_nxt = emit;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_START;
      digit_r     <= 2'd0;
      high_r      <= 4'd0;
      remain_r    <= 8'd0;
      addr_r      <= 16'd0;
      sum_r       <= 8'd0;
      rec_r       <= 16'd1;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (go) begin
        phase_r  <= phase_nxt;
        digit_r  <= digit_nxt;
        high_r   <= high_nxt;
        remain_r <= remain_nxt;
        addr_r   <= addr_nxt;
        sum_r    <= sum_nxt;
        rec_r    <= rec_nxt;
      end
    end
  end

  // Load result payload
  always_ff @(posedge clk) begin
    if (go && emit) begin
      kind_r  <= res_kind;
      data_r  <= res_data;
      baddr_r <= res_addr;
      recno_r <= rec_r;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.kind          = kind_r;
  assign out_ch.data_byte     = data_r;
  assign out_ch.byte_address  = baddr_r;
  assign out_ch.record_number = recno_r;

`ifndef SYNTHESIS
  a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DONE |=> phase_r == PH_DONE)
    else $error("parser left the stopped phase");

  a_rec_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    rec_r != 16'd0)
    else $error("record counter reached zero");

  // A stop inside the address field leaves the digit index where it was
  a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r != PH_ADDR && phase_r != PH_DONE |-> digit_r[1] == 1'b0)
    else $error("digit index beyond a byte pair outside the address");

  a_no_emit_done: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DONE && go |=> !out_valid_r || $stable(recno_r))
    else $error("result produced after stop");
`endif

endmodule

FILE: hw/rtl/intel_hex_record_decoder_unit.sv
// Throughput: one character per cycle while the sink takes results.
// A two-entry queue sits between classifier and parser; a result register holds output.
// Reset (synchronous, active low) empties the queue and result stage, sets the parser to
// wait for a record colon and sets the record counter to one.
// Top level of the hex record decoder: classifier, queue and parser.
module intel_hex_record_decoder_unit (
  input logic         clk,
  input logic         rst_n,
  ihexd_in_if.sink    in_ch,
  ihexd_out_if.source out_ch
);
  import ihexd_pkg::*;

  logic  push_valid, push_ready;
  item_t push_item;
  logic  pop_valid, pop_ready;
  item_t pop_item;

  // Classify incoming characters
  ihexd_front u_front (
    .in_ch      (in_ch),
    .push_ready (push_ready),
    .push_valid (push_valid),
    .push_item  (push_item)
  );

  // Decouple classifier from parser
  ihexd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  // Parse records and emit results
  ihexd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item),
    .out_ch    (out_ch)
  );

endmodule

FILE: sim/tb.sv
// Testbench for the hex record decoder: directed records, random record streams, self-check.
`timescale 1ns / 1ps

module tb;
  import ihexd_pkg::*;

  localparam int ITEMS     = 1050;
  localparam int LIMIT     = 300000;
  localparam int HOLD_AT   = 30;
  localparam int HOLD_LEN  = 400;
  localparam int DRAIN_LEN = 40;
  localparam int DIR_ROWS  = 27;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data;
    logic [15:0] addr;
    logic [15:0] recno;
  } res_t;

  typedef struct packed {
    logic [7:0] c;
    logic       fixed;
    res_t       r;
  } row_t;

  localparam res_t NO_RES = '0;

  logic clk;
  logic rst_n;

  ihexd_in_if  in_if();
  ihexd_out_if out_if();

  intel_hex_record_decoder_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  // Decoder state as the checker sees it
  phase_t      ph;
  int          dig;
  logic [3:0]  hi_nib;
  logic [7:0]  left;
  logic [15:0] cur_addr;
  logic [7:0]  sum;
  logic [15:0] rec_cnt;

  res_t pending_results[$];
  int   fail_cnt   = 0;
  int   items_sent = 0;
  int   cycle_cnt  = 0;
  bit   send_burst = 0;

  // Directed records: one with data at the top address and a bad checksum, then
  // whitespace and a clean record at address zero
  row_t dir_tab [DIR_ROWS] = '{
    '{":", 1'b0, NO_RES}, '{"0", 1'b0, NO_RES}, '{"1", 1'b0, NO_RES},
    '{"F", 1'b0, NO_RES}, '{"F", 1'b0, NO_RES}, '{"f", 1'b0, NO_RES},
    '{"f", 1'b0, NO_RES}, '{8'h80, 1'b0, NO_RES}, '{8'hFF, 1'b0, NO_RES},
    '{"F", 1'b0, NO_RES}, '{"F", 1'b1, '{KIND_DATA, 8'hFF, 16'hFFFF, 16'd1}},
    '{"0", 1'b0, NO_RES}, '{"0", 1'b1, '{KIND_WARN, 8'h00, 16'h0000, 16'd1}},
    '{8'h0A, 1'b0, NO_RES}, '{":", 1'b0, NO_RES}, '{"0", 1'b0, NO_RES},
    '{"1", 1'b0, NO_RES}, '{"0", 1'b0, NO_RES}, '{"0", 1'b0, NO_RES},
    '{"0", 1'b0, NO_RES}, '{"0", 1'b0, NO_RES}, '{"0", 1'b0, NO_RES},
    '{"0", 1'b0, NO_RES}, '{"0", 1'b0, NO_RES},
    '{"0", 1'b1, '{KIND_DATA, 8'h00, 16'h0000, 16'd2}},
    '{"F", 1'b0, NO_RES}, '{"F", 1'b0, NO_RES}
  };

  // Clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Return {valid, value} of a hex digit character
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    if (c >= "0" && c <= "9") return {1'b1, c[3:0]};
    if ((c >= "A" && c <= "F") || (c >= "a" && c <= "f")) return {1'b1, c[3:0] + 4'd9};
    return 5'd0;
  endfunction

  function automatic bit is_ws(input logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  // Encode a nibble as a hex digit, letters in either case
  function automatic logic [7:0] hex_digit(input logic [3:0] n);
    if (n < 4'd10) return 8'h30 + {4'h0, n};
    return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + {4'h0, n} - 8'd10;
  endfunction

  function automatic logic [7:0] non_hex_char();
    logic [7:0] c;
    logic [4:0] hv;
    do begin
      c  = 8'($urandom_range(0, 255));
      hv = hex_val(c);
    end while (hv[4]);
    return c;
  endfunction

  function automatic logic [7:0] ws_char();
    logic [7:0] c;
    c = 8'($urandom_range(8'h09, 8'h0E));
    return (c == 8'h0E) ? 8'h20 : c;
  endfunction

  // Advance the decoder state by one character; flag a result if one is due
  task automatic decode_char(input logic [7:0] c, output bit hit, output res_t r);
    logic [4:0] hv;
    logic [7:0] b;
    hit = 1'b0;
    r = '0;
    r.recno = rec_cnt;
    hv = hex_val(c);
    case (ph)
      PH_START: begin
        if (c == ":") begin
          ph = PH_COUNT;
          dig = 0;
        end else if (!(rec_cnt > 16'd1 && is_ws(c))) begin
          ph = PH_DONE;
          hit = 1'b1;
          r.kind = KIND_FAIL;
        end
      end
      PH_TYPE: begin
        if (dig == 0) begin
          dig = 1;
        end else begin
          dig = 0;
          ph = (left != 8'd0) ? PH_DATA : PH_CSUM;
        end
      end
      PH_DONE: ;
      default: begin
        if (!hv[4]) begin
          ph = PH_DONE;
          hit = 1'b1;
          r.kind = KIND_FAIL;
        end else if (ph == PH_ADDR) begin
          cur_addr = {cur_addr[11:0], hv[3:0]};
          if (dig < 3) begin
            dig++;
          end else begin
            dig = 0;
            sum = sum + cur_addr[15:8] + cur_addr[7:0];
            ph = PH_TYPE;
          end
        end else if (dig == 0) begin
          hi_nib = hv[3:0];
          dig = 1;
        end else begin
          dig = 0;
          b = {hi_nib, hv[3:0]};
          case (ph)
            PH_COUNT: begin
              left = b;
              sum = b;
              cur_addr = '0;
              if (b == 8'd0) begin
                ph = PH_DONE;
                hit = 1'b1;
                r.kind = KIND_OK;
              end else begin
                ph = PH_ADDR;
              end
            end
            PH_DATA: begin
              hit = 1'b1;
              r.kind = KIND_DATA;
              r.data = b;
              r.addr = cur_addr;
              sum = sum + b;
              cur_addr = cur_addr + 16'd1;
              left = left - 8'd1;
              if (left == 8'd0) ph = PH_CSUM;
            end
            default: begin
              if (8'(-sum) != b) begin
                hit = 1'b1;
                r.kind = KIND_WARN;
              end
              if (rec_cnt < 16'hFFFF) rec_cnt = rec_cnt + 16'd1;
              ph = PH_START;
            end
          endcase
        end
      end
    endcase
  endtask

  // Offer one character; hold the request until accepted, then predict its result
  task automatic send_char(input logic [7:0] c, input logic fixed = 1'b0,
                           input res_t fixed_res = '0);
    int   gap;
    bit   hit;
    res_t r;
    if (items_sent % 64 == 0) send_burst = ($urandom_range(0, 2) == 0);
    gap = send_burst ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.char_in <= c;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    items_sent++;
    decode_char(c, hit, r);
    if (fixed) pending_results.push_back(fixed_res);
    else if (hit) pending_results.push_back(r);
  endtask

  // Build one record, optionally with a wrong checksum or one bad hex digit, and send it
  task automatic send_record(input int cnt, input bit bad_sum, input bit corrupt);
    logic [7:0]  fld[$];
    logic [7:0]  rec[$];
    int          hexpos[$];
    logic [15:0] addr;
    logic [7:0]  s;
    addr = ($urandom_range(0, 7) == 0) ? (16'hFFF0 | 16'($urandom_range(0, 15)))
                                       : 16'($urandom());
    fld.push_back(8'(cnt));
    fld.push_back(addr[15:8]);
    fld.push_back(addr[7:0]);
    for (int i = 0; i < cnt; i++) fld.push_back(8'($urandom_range(0, 255)));
    s = '0;
    foreach (fld[i]) s = s + fld[i];
    s = -s;
    if (bad_sum) s = s ^ 8'($urandom_range(1, 255));
    fld.push_back(s);
    rec.push_back(":");
    foreach (fld[i]) begin
      if (i == 3) begin
        rec.push_back(8'($urandom_range(0, 255)));
        rec.push_back(8'($urandom_range(0, 255)));
      end
      hexpos.push_back(rec.size());
      rec.push_back(hex_digit(fld[i][7:4]));
      hexpos.push_back(rec.size());
      rec.push_back(hex_digit(fld[i][3:0]));
    end
    if (corrupt) rec[hexpos[$urandom_range(0, hexpos.size() - 1)]] = non_hex_char();
    foreach (rec[i]) send_char(rec[i]);
  endtask

  // Stimulus
  initial begin
    int         nrec;
    int         cnt;
    logic [7:0] c;
    ph       = PH_START;
    dig      = 0;
    hi_nib   = '0;
    left     = '0;
    cur_addr = '0;
    sum      = '0;
    rec_cnt  = 16'd1;
    in_if.valid   = 1'b0;
    in_if.char_in = '0;
    rst_n = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIR_ROWS; i++) begin
      send_char(dir_tab[i].c, dir_tab[i].fixed, dir_tab[i].r);
    end

    // Pause the sender until every pending result is out
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);

    // Random records, some with a wrong checksum, one of them at full length
    nrec = 0;
    while (items_sent < ITEMS) begin
      repeat ($urandom_range(0, 2)) send_char(ws_char());
      if (nrec == 12) cnt = 255;
      else if ($urandom_range(0, 19) == 0) cnt = $urandom_range(9, 40);
      else cnt = $urandom_range(1, 8);
      send_record(cnt, $urandom_range(0, 7) == 0, 1'b0);
      if ($urandom_range(0, 15) == 0) begin
        in_if.valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
      end
      nrec++;
    end

    // End the stream: bad record start, end record, or a broken hex digit
    case ($urandom_range(0, 2))
      0: begin
        do c = 8'($urandom_range(0, 255)); while (c == ":" || is_ws(c));
        send_char(c);
      end
      1: send_record(0, 1'b0, 1'b0);
      default: send_record($urandom_range(1, 8), 1'b0, 1'b1);
    endcase
    // Everything after the stop is dropped
    repeat (8) send_char(8'($urandom_range(0, 255)));

    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_LEN) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("intel_hex_record_decoder_unit: match");
    end else begin
      $display("intel_hex_record_decoder_unit: mismatch");
    end
    $finish;
  end

  // Receiver: random stalls, calm stretches, and one long hold-off
  initial begin
    int gap;
    int n;
    bit burst;
    out_if.ready = 1'b0;
    n = 0;
    burst = 0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (n % 48 == 0) burst = ($urandom_range(0, 2) == 0);
      gap = burst ? 0 : $urandom_range(0, 19);
      if (n == HOLD_AT) gap = HOLD_LEN;
      if (gap > 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      @(posedge clk);
      while (!out_if.valid) @(posedge clk);
      n++;
    end
  end

  // Compare each accepted result with the oldest pending one
  always @(posedge clk) begin : check_blk
    res_t e;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual kind %0d data %h addr %h rec %0d",
                 $time, out_if.kind, out_if.data_byte, out_if.byte_address,
                 out_if.record_number);
        fail_cnt++;
      end else begin
        e = pending_results.pop_front();
        if (out_if.kind !== e.kind) begin
          $display("%0t: kind: expected %0d actual %0d", $time, e.kind, out_if.kind);
          fail_cnt++;
        end
        if (out_if.data_byte !== e.data) begin
          $display("%0t: data_byte: expected %h actual %h", $time, e.data, out_if.data_byte);
          fail_cnt++;
        end
        if (out_if.byte_address !== e.addr) begin
          $display("%0t: byte_address: expected %h actual %h", $time, e.addr,
                   out_if.byte_address);
          fail_cnt++;
        end
        if (out_if.record_number !== e.recno) begin
          $display("%0t: record_number: expected %0d actual %0d", $time, e.recno,
                   out_if.record_number);
          fail_cnt++;
        end
      end
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == LIMIT) begin
      $display("intel_hex_record_decoder_unit: mismatch");
      $finish;
    end
  end

endmodule

FILE: intel_hex_record_decoder_unit.f
hw/rtl/ihexd_pkg.sv
hw/rtl/ihexd_if.sv
hw/rtl/ihexd_front.sv
hw/rtl/ihexd_queue.sv
hw/rtl/ihexd_back.sv
hw/rtl/intel_hex_record_decoder_unit.sv
sim/tb.sv
